>>> rtl/twcw_pkg.sv
// Package for the text window cursor writer: command codes, character codes,
// field widths and the command list types. Depends on nothing.
`default_nettype none

package twcw_pkg;

   localparam int ScreenColW = 7;
   localparam int ScreenRowW = 6;
   localparam int GlyphW     = 8;
   localparam int CmdW       = 2;
   localparam int MaxCmds    = 4;

   localparam logic [CmdW-1:0] CMD_INVERT = 2'd0;
   localparam logic [CmdW-1:0] CMD_WRITE  = 2'd1;
   localparam logic [CmdW-1:0] CMD_SCROLL = 2'd2;
   localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd3;

   localparam logic [GlyphW-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [GlyphW-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [GlyphW-1:0] CH_SPACE     = 8'd32;
   localparam logic [GlyphW-1:0] GLYPH_NONE   = 8'd0;

   localparam logic REG_ORIGIN_COL = 1'b0;
   localparam logic REG_ORIGIN_ROW = 1'b1;

   typedef struct packed {
      logic [CmdW-1:0]       command;
      logic [ScreenColW-1:0] screen_col;
      logic [ScreenRowW-1:0] screen_row;
      logic [GlyphW-1:0]     glyph;
   } cmd_type;

   typedef struct packed {
      cmd_type [MaxCmds-1:0] slot;
      logic [1:0]            count_m1;
   } cmd_list_type;

endpackage

`default_nettype wire

>>> rtl/twcw_if.sv
// Handshake interfaces for the character, command and register write channels.
// Depends on twcw_pkg for the field widths.
`default_nettype none

interface twcw_req_if import twcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [GlyphW-1:0] character;
   logic              home;
   modport source (output valid, output character, output home, input ready);
   modport sink (input valid, input character, input home, output ready);
endinterface

interface twcw_rsp_if import twcw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CmdW-1:0]       command;
   logic [ScreenColW-1:0] screen_col;
   logic [ScreenRowW-1:0] screen_row;
   logic [GlyphW-1:0]     glyph;
   logic                  last;
   modport source (output valid, output command, output screen_col, output screen_row,
                   output glyph, output last, input ready);
   modport sink (input valid, input command, input screen_col, input screen_row,
                 input glyph, input last, output ready);
endinterface

interface twcw_csr_if import twcw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  index;
   logic [ScreenColW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/twcw_step.sv
// Combinational step logic: from the cursor, the origin and one item it forms
// the command list and the next cursor. Depends on twcw_pkg.
`default_nettype none

module twcw_step import twcw_pkg::*; #(
   parameter int COLS = 64,
   parameter int ROWS = 16
) (
   input  wire logic [$clog2(COLS)-1:0] cur_col,
   input  wire logic [$clog2(ROWS)-1:0] cur_row,
   input  wire logic [ScreenColW-1:0]   origin_col,
   input  wire logic [ScreenRowW-1:0]   origin_row,
   input  wire logic [GlyphW-1:0]       character,
   input  wire logic                    home,
   output cmd_list_type                 list,
   output logic [$clog2(COLS)-1:0]      next_col,
   output logic [$clog2(ROWS)-1:0]      next_row
);

   localparam int ColW = $clog2(COLS);
   localparam int RowW = $clog2(ROWS);
   localparam logic [ColW:0]   ColsVal = (ColW+1)'(COLS);
   localparam logic [RowW:0]   RowsVal = (RowW+1)'(ROWS);
   localparam logic [ColW-1:0] ColLast = ColW'(COLS - 1);
   localparam logic [RowW-1:0] RowLast = RowW'(ROWS - 1);

   logic [ColW:0]   col_inc;
   logic [RowW:0]   row_inc;
   logic [ColW-1:0] mid_col;
   logic [RowW:0]   mid_row;
   logic [ColW-1:0] wr_col;
   logic [RowW-1:0] wr_row;
   logic [GlyphW-1:0] wr_glyph;
   logic            has_write;
   logic            has_scroll;
   logic [1:0]      n;

   assign col_inc = {1'b0, cur_col} + (ColW+1)'(1);
   assign row_inc = {1'b0, cur_row} + (RowW+1)'(1);

   always_comb begin
      mid_col   = cur_col;
      mid_row   = {1'b0, cur_row};
      wr_col    = cur_col;
      wr_row    = cur_row;
      wr_glyph  = character;
      has_write = 1'b1;
      if (character == CH_NEWLINE) begin
         has_write = 1'b0;
         mid_col   = '0;
         mid_row   = row_inc;
      end else if (character == CH_BACKSPACE) begin
         if (cur_col != '0) begin
            mid_col = cur_col - ColW'(1);
         end else if (cur_row != '0) begin
            mid_col = ColLast;
            mid_row = {1'b0, cur_row - RowW'(1)};
         end
         wr_col   = mid_col;
         wr_row   = mid_row[RowW-1:0];
         wr_glyph = CH_SPACE;
      end else begin
         if (col_inc >= ColsVal) begin
            mid_col = '0;
            mid_row = row_inc;
         end else begin
            mid_col = col_inc[ColW-1:0];
         end
      end
      has_scroll = (mid_row >= RowsVal);
      next_col   = mid_col;
      next_row   = has_scroll ? RowLast : mid_row[RowW-1:0];

      list = '0;
      n    = 2'd0;
      if (home) begin
         next_col = '0;
         next_row = '0;
         list.slot[0] = '{CMD_CLEAR, origin_col, origin_row, GLYPH_NONE};
         list.count_m1 = 2'd0;
      end else begin
         list.slot[n] = '{CMD_INVERT, origin_col + ScreenColW'(cur_col),
                          origin_row + ScreenRowW'(cur_row), GLYPH_NONE};
         n = n + 2'd1;
         if (has_write) begin
            list.slot[n] = '{CMD_WRITE, origin_col + ScreenColW'(wr_col),
                             origin_row + ScreenRowW'(wr_row), wr_glyph};
            n = n + 2'd1;
         end
         if (has_scroll) begin
            list.slot[n] = '{CMD_SCROLL, origin_col, origin_row, GLYPH_NONE};
            n = n + 2'd1;
         end
         list.slot[n] = '{CMD_INVERT, origin_col + ScreenColW'(next_col),
                          origin_row + ScreenRowW'(next_row), GLYPH_NONE};
         list.count_m1 = n;
      end
   end

endmodule

`default_nettype wire

>>> rtl/text_window_cursor_writer_top.sv
// Latency: the first command of an item is offered in the cycle after the item is taken.
// Throughput: one command per cycle from the output register while rsp_bus.ready is high;
// an item is 1-4 commands (one for home, two or three for newline, up to four otherwise).
// The next item is taken in the cycle that the last command of the previous one leaves.
// Reset (synchronous, active high) clears the cursor, the origin and the busy flag.
// Depends on twcw_pkg, twcw_if and twcw_step.
`default_nettype none

module text_window_cursor_writer_top import twcw_pkg::*; #(
   parameter int COLS = 64,
   parameter int ROWS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   twcw_req_if.sink   req_bus,
   twcw_rsp_if.source rsp_bus,
   twcw_csr_if.sink   csr_bus
);

   localparam int ColW = $clog2(COLS);
   localparam int RowW = $clog2(ROWS);

   logic [ColW-1:0]       col_ff;
   logic [RowW-1:0]       row_ff;
   logic [ScreenColW-1:0] origin_col_ff;
   logic [ScreenRowW-1:0] origin_row_ff;
   cmd_list_type          job_ff, job_in;
   logic                  busy_ff, busy_in;

   cmd_list_type    step_list;
   logic [ColW-1:0] step_col;
   logic [RowW-1:0] step_row;
   logic            accept;
   logic            take;
   logic            at_last;

   twcw_step #(.COLS(COLS), .ROWS(ROWS)) u_step (
      .cur_col    (col_ff),
      .cur_row    (row_ff),
      .origin_col (origin_col_ff),
      .origin_row (origin_row_ff),
      .character  (req_bus.character),
      .home       (req_bus.home),
      .list       (step_list),
      .next_col   (step_col),
      .next_row   (step_row)
   );

   assign at_last       = (job_ff.count_m1 == 2'd0);
   assign take          = busy_ff && rsp_bus.ready;
   assign req_bus.ready = !busy_ff || (rsp_bus.ready && at_last);
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid      = busy_ff;
   assign rsp_bus.command    = job_ff.slot[0].command;
   assign rsp_bus.screen_col = job_ff.slot[0].screen_col;
   assign rsp_bus.screen_row = job_ff.slot[0].screen_row;
   assign rsp_bus.glyph      = job_ff.slot[0].glyph;
   assign rsp_bus.last       = at_last;

   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      if (accept) begin
         job_in  = step_list;
         busy_in = 1'b1;
      end else if (take) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            job_in.slot     = {cmd_type'('0), job_ff.slot[MaxCmds-1:1]};
            job_in.count_m1 = job_ff.count_m1 - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (reset) begin
         busy_ff       <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         origin_col_ff <= '0;
         origin_row_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         if (accept) begin
            col_ff <= step_col;
            row_ff <= step_row;
         end
         if (csr_bus.valid) begin
            case (csr_bus.index)
               REG_ORIGIN_COL: origin_col_ff <= csr_bus.data;
               REG_ORIGIN_ROW: origin_row_ff <= csr_bus.data[ScreenRowW-1:0];
               default: ;
            endcase
         end
      end
   end

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < (ColW+1)'(COLS))
      else $error("cursor column outside the window");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} < (RowW+1)'(ROWS))
      else $error("cursor row outside the window");

   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.command == CMD_CLEAR |-> rsp_bus.last)
      else $error("clear command is not the only command of its item");

   a_scroll_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.command == CMD_SCROLL |-> !rsp_bus.last)
      else $error("scroll command ends an item");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept && busy_ff |-> rsp_bus.ready && rsp_bus.last)
      else $error("item taken while earlier commands are still pending");

endmodule

`default_nettype wire
